// ----- src/ppu_pkg.sv -----
// ppu_pkg: shared types, register codes and helper functions
// for the particle pool update block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

  localparam int SLOT_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VEL_SPREAD_X = 3'd0,
    REG_VEL_SPREAD_Y = 3'd1,
    REG_SIZE_SPREAD  = 3'd2,
    REG_SIZE_START   = 3'd3,
    REG_SIZE_FINAL   = 3'd4,
    REG_COLOR_START  = 3'd5,
    REG_COLOR_FINAL  = 3'd6,
    REG_LIFE_SPAN    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_EMIT = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [23:0] vel_spread_x;
    logic [23:0] vel_spread_y;
    logic [14:0] size_spread;
    logic [14:0] size_start;
    logic [14:0] size_final;
    logic [31:0] color_start;
    logic [31:0] color_final;
    logic [23:0] life_span;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        dt;
    logic [63:0]        rand_bits;
  } item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [15:0]        angle;
    logic signed [24:0] life_left;
    logic [23:0]        life_total;
    logic signed [15:0] size_birth;
    logic signed [15:0] size_death;
    logic [31:0]        color_start;
    logic [31:0]        color_final;
  } entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        angle;
    logic signed [15:0] size;
    logic [31:0]        color;
    logic               present;
    logic               last;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sh7FFF) r = 16'sh7FFF;
    else if (v < -34'sh8000) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/ppu_ram.sv -----
// ppu_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- src/ppu_front.sv -----
// ppu_front: input handshake, decode of the item kind and a two-entry queue
// toward the execution side. Depends on ppu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppu_front import ppu_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                func,
  input  wire signed [31:0]  pos_x,
  input  wire signed [31:0]  pos_y,
  input  wire signed [31:0]  vel_x,
  input  wire signed [31:0]  vel_y,
  input  wire  [15:0]        dt,
  input  wire  [63:0]        rand_bits,
  output logic               head_valid,
  output item_t              head,
  input  wire                pop
);
  item_t      q [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       push;
  item_t      item_in;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rp];

  always_comb begin
    item_in.op        = func ? OP_TICK : OP_EMIT;
    item_in.pos_x     = pos_x;
    item_in.pos_y     = pos_y;
    item_in.vel_x     = vel_x;
    item_in.vel_y     = vel_y;
    item_in.dt        = dt;
    item_in.rand_bits = rand_bits;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop && head_valid) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop && head_valid};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> (wp == rp)) else $error("queue pointers disagree");
endmodule
`default_nettype wire

// ----- src/ppu_back.sv -----
// ppu_back: executes emits and pool walks, owns the particle store, the
// life divider and the result registers. Depends on ppu_pkg and ppu_ram.
`timescale 1ns / 1ps
`default_nettype none
module ppu_back import ppu_pkg::*; #(
  parameter int POOL = 64,
  parameter int SPIN_RATE = 104
) (
  input  wire         clk,
  input  wire         rst,
  input  cfg_t        cfg,
  input  wire         head_valid,
  input  item_t       head,
  output logic        pop,
  output logic        out_valid,
  input  wire         out_ready,
  output result_t     res_out
);
  localparam int IDX_W = $clog2(POOL);
  localparam int ENT_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT_MUL, S_EMIT_WR, S_ADDR, S_CHECK, S_DIV,
    S_MUL1, S_MUL2, S_MUL3, S_PUSH, S_END
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   write_slot;
  logic [POOL-1:0]    alive;
  logic               pend_valid;
  result_t            pend;
  result_t            res;
  result_t            empty_res;

  logic [25:0]        rem;
  logic [16:0]        quo;
  logic [4:0]         cnt;
  logic [16:0]        f;

  logic signed [41:0] prod_sx;
  logic signed [41:0] prod_sy;
  logic signed [32:0] prod_sz;
  logic signed [34:0] size_prod;
  logic signed [26:0] col_prod [4];
  logic signed [48:0] vx_prod;
  logic signed [48:0] vy_prod;
  logic [31:0]        spin_prod;
  logic signed [24:0] ll_new;
  logic signed [31:0] px_new;
  logic [7:0]         col_byte [4];
  logic [24:0]        alpha_prod;
  logic signed [15:0] size_new;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic               ram_re;
  entry_t             e;
  logic [ENT_W-1:0]   rdata;

  // combinational helpers
  logic signed [16:0] r_vx, r_vy, r_sz;
  logic signed [17:0] f_s;
  logic signed [16:0] dt_s;
  logic [25:0]        shifted;
  logic               out_free;
  logic               out_set;
  entry_t             e_emit;
  entry_t             e_upd;
  logic signed [8:0]  col_d [4];
  logic signed [26:0] col_sum [4];
  logic signed [33:0] px_sum, py_sum;

  assign e = entry_t'(rdata);

  ppu_ram #(.WIDTH(ENT_W), .DEPTH(POOL)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx),
    .rdata(rdata)
  );

  always_comb begin
    r_vx     = $signed({1'b0, head.rand_bits[31:16]}) - 17'sd32768;
    r_vy     = $signed({1'b0, head.rand_bits[47:32]}) - 17'sd32768;
    r_sz     = $signed({1'b0, head.rand_bits[63:48]}) - 17'sd32768;
    f_s      = $signed({1'b0, f});
    dt_s     = $signed({1'b0, head.dt});
    shifted  = (cnt == 5'd0) ? rem : {rem[24:0], 1'b0};
    out_free = !out_valid || out_ready;
    out_set  = out_free && (((state == S_PUSH) && pend_valid) || (state == S_END));

    for (int k = 0; k < 4; k++) begin
      col_d[k]   = $signed({1'b0, e.color_start[8*k +: 8]}) -
                   $signed({1'b0, e.color_final[8*k +: 8]});
      col_sum[k] = (col_prod[k] >>> 16) + 27'($signed({1'b0, e.color_final[8*k +: 8]}));
    end

    px_sum = 34'(e.px) + 34'(vx_prod >>> 16);
    py_sum = 34'(e.py) + 34'(vy_prod >>> 16);

    e_emit.px          = head.pos_x;
    e_emit.py          = head.pos_y;
    e_emit.vx          = sat32(34'(head.vel_x) + 34'(prod_sx >>> 16));
    e_emit.vy          = sat32(34'(head.vel_y) + 34'(prod_sy >>> 16));
    e_emit.angle       = head.rand_bits[15:0];
    e_emit.life_left   = $signed({1'b0, cfg.life_span});
    e_emit.life_total  = cfg.life_span;
    e_emit.size_birth  = sat16(34'($signed({1'b0, cfg.size_start})) + 34'(prod_sz >>> 16));
    e_emit.size_death  = $signed({1'b0, cfg.size_final});
    e_emit.color_start = cfg.color_start;
    e_emit.color_final = cfg.color_final;

    e_upd           = e;
    e_upd.px        = px_new;
    e_upd.py        = sat32(py_sum);
    e_upd.angle     = e.angle + spin_prod[31:16];
    e_upd.life_left = ll_new;

    empty_res      = '0;
    empty_res.last = 1'b1;

    ram_we    = (state == S_EMIT_WR) || (state == S_MUL3);
    ram_waddr = (state == S_EMIT_WR) ? write_slot : idx;
    ram_wdata = (state == S_EMIT_WR) ? ENT_W'(e_emit) : ENT_W'(e_upd);
    ram_re    = (state == S_ADDR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      write_slot <= LAST_IDX;
      alive      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      pop        <= 1'b0;
    end else begin
      pop       <= (state == S_EMIT_WR) || ((state == S_END) && out_free);
      out_valid <= out_set || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (head_valid && !pop) begin
            if (head.op == OP_EMIT) begin
              state <= S_EMIT_MUL;
            end else begin
              idx   <= '0;
              state <= S_ADDR;
            end
          end
        end
        S_EMIT_MUL: begin
          prod_sx <= $signed({1'b0, cfg.vel_spread_x}) * r_vx;
          prod_sy <= $signed({1'b0, cfg.vel_spread_y}) * r_vy;
          prod_sz <= $signed({1'b0, cfg.size_spread}) * r_sz;
          state   <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          alive[write_slot] <= 1'b1;
          write_slot <= (write_slot == '0) ? LAST_IDX : write_slot - 1'b1;
          state <= S_IDLE;
        end
        S_ADDR: begin
          if (alive[idx]) begin
            state <= S_CHECK;
          end else if (idx == LAST_IDX) begin
            state <= S_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CHECK: begin
          if (e.life_left <= 25'sd0) begin
            alive[idx] <= 1'b0;
            if (idx == LAST_IDX) begin
              state <= S_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ADDR;
            end
          end else if (e.life_total == '0) begin
            f     <= 17'h10000;
            state <= S_MUL1;
          end else begin
            rem   <= {2'b00, e.life_left[23:0]};
            quo   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (shifted >= {2'b00, e.life_total}) begin
            rem <= shifted - {2'b00, e.life_total};
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= shifted;
            quo <= {quo[15:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'd16) begin
            f     <= (shifted >= {2'b00, e.life_total}) ? {quo[15:0], 1'b1}
                                                        : {quo[15:0], 1'b0};
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          size_prod <= (17'(e.size_birth) - 17'(e.size_death)) * f_s;
          for (int k = 0; k < 4; k++) begin
            col_prod[k] <= 27'(col_d[k]) * 27'(f_s);
          end
          vx_prod   <= e.vx * dt_s;
          spin_prod <= 32'(SPIN_RATE) * {16'd0, head.dt};
          ll_new    <= e.life_left - $signed({8'd0, head.dt, 1'b0});
          state     <= S_MUL2;
        end
        S_MUL2: begin
          for (int k = 0; k < 4; k++) begin
            col_byte[k] <= col_sum[k][7:0];
          end
          alpha_prod <= {17'd0, col_sum[0][7:0]} * {8'd0, f};
          vy_prod    <= e.vy * dt_s;
          px_new     <= sat32(px_sum);
          size_new   <= e.size_death + 16'(size_prod >>> 16);
          state      <= S_MUL3;
        end
        S_MUL3: begin
          res.slot    <= SLOT_W'(idx);
          res.x       <= px_new;
          res.y       <= sat32(py_sum);
          res.angle   <= e.angle + spin_prod[31:16];
          res.size    <= size_new;
          res.color   <= {col_byte[3], col_byte[2], col_byte[1], alpha_prod[23:16]};
          res.present <= 1'b1;
          res.last    <= 1'b0;
          state       <= S_PUSH;
        end
        S_PUSH: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              res_out <= pend;
            end
            pend       <= res;
            pend_valid <= 1'b1;
            if (idx == LAST_IDX) begin
              state <= S_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ADDR;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            if (pend_valid) begin
              res_out      <= pend;
              res_out.last <= 1'b1;
            end else begin
              res_out <= empty_res;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ws_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= LAST_IDX) else $error("write slot out of range");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1) |-> (f <= 17'h10000)) else $error("life fraction above one");
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid) else $error("held result outside a tick");
  a_retire: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && e.life_left <= 25'sd0) |=> !alive[$past(idx)])
    else $error("expired particle not retired");
endmodule
`default_nettype wire

// ----- src/particle_pool_update.sv -----
// particle_pool_update: top level; configuration registers, front queue and
// execution side. Depends on ppu_pkg, ppu_front, ppu_back, ppu_ram.
//
// Usage: items enter on in_valid/in_ready. func = 0 emits one particle into
// the pool slot that a down-counting write pointer selects; it gives no result.
// func = 1 advances time by dt: every pool slot is visited in order and each
// live particle produces one result on out_valid/out_ready, the final one
// flagged by last. A tick with no live particle gives one result with
// present = 0 and last = 1. The user writes configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle; it is not enforced.
// Flow: an emit holds the execution side until its entry is written to the
// store. A tick visits each slot in order: an empty slot is skipped, an
// expiring slot is retired and a live slot goes through the 17-step life
// divider and three multiply stages sharing one store port. The two-entry
// input queue takes one more item while a tick runs; one result is held
// back to mark the last, and an output register parts the block from the
// receiver, whose stall pauses the pool walk.
// Reset clears the live flags, sets the write pointer to the top slot and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_update import ppu_pkg::*; #(
  parameter int POOL = 64,
  parameter int SPIN_RATE = 104
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    func,
  input  wire signed [31:0]      pos_x,
  input  wire signed [31:0]      pos_y,
  input  wire signed [31:0]      vel_x,
  input  wire signed [31:0]      vel_y,
  input  wire  [15:0]            dt,
  input  wire  [63:0]            rand_bits,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [SLOT_W-1:0]      slot,
  output logic signed [31:0]     draw_x,
  output logic signed [31:0]     draw_y,
  output logic [15:0]            draw_angle,
  output logic signed [15:0]     draw_size,
  output logic [31:0]            draw_color,
  output logic                   present,
  output logic                   last,
  input  wire                    cfg_we,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);
  cfg_t    cfg;
  item_t   head;
  logic    head_valid;
  logic    pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vel_spread_x <= 24'd0;
      cfg.vel_spread_y <= 24'd0;
      cfg.size_spread  <= 15'd0;
      cfg.size_start   <= 15'd256;
      cfg.size_final   <= 15'd0;
      cfg.color_start  <= 32'hFFFF_FFFF;
      cfg.color_final  <= 32'd0;
      cfg.life_span    <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VEL_SPREAD_X: cfg.vel_spread_x <= cfg_data[23:0];
        REG_VEL_SPREAD_Y: cfg.vel_spread_y <= cfg_data[23:0];
        REG_SIZE_SPREAD:  cfg.size_spread  <= cfg_data[14:0];
        REG_SIZE_START:   cfg.size_start   <= cfg_data[14:0];
        REG_SIZE_FINAL:   cfg.size_final   <= cfg_data[14:0];
        REG_COLOR_START:  cfg.color_start  <= cfg_data;
        REG_COLOR_FINAL:  cfg.color_final  <= cfg_data;
        REG_LIFE_SPAN:    cfg.life_span    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  ppu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .dt        (dt),
    .rand_bits (rand_bits),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  ppu_back #(.POOL(POOL), .SPIN_RATE(SPIN_RATE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res)
  );

  assign slot       = res.slot;
  assign draw_x     = res.x;
  assign draw_y     = res.y;
  assign draw_angle = res.angle;
  assign draw_size  = res.size;
  assign draw_color = res.color;
  assign present    = res.present;
  assign last       = res.last;
endmodule
`default_nettype wire
